@@ hw/rtl/descriptor_medoid_by_median_hamming_assert.svh @@
// ----------------------------------------------------------------------------
// descriptor medoid assertion macros
// shorthand for clocked assertions with synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_MEDOID_BY_MEDIAN_HAMMING_ASSERT_SVH
`define DESCRIPTOR_MEDOID_BY_MEDIAN_HAMMING_ASSERT_SVH

// property holds on every cycle out of reset
`define DMMH_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define DMMH_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dmmh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmh_pkg
// shared constants, types and states of the descriptor medoid selector
// ----------------------------------------------------------------------------
package dmmh_pkg;

  localparam int MAX_DESC  = 32;
  localparam int DESC_BITS = 256;

  localparam int WORD_W    = 64;
  localparam int WORDS     = 4;
  localparam int ROW_W     = WORD_W * WORDS;
  // only the low bits take part, the input carries no more than ROW_W
  localparam int USED_BITS = (DESC_BITS < ROW_W) ? DESC_BITS : ROW_W;

  localparam int IDX_W  = (MAX_DESC > 1) ? $clog2(MAX_DESC) : 1;
  localparam int CNT_W  = $clog2(MAX_DESC + 1);
  // column counter runs up to n + 2 while the last column drains the pipeline
  localparam int J_W    = $clog2(MAX_DESC + 3);
  localparam int DIST_W = $clog2(USED_BITS + 1);
  localparam int PC_W   = $clog2(WORD_W + 1);
  localparam int BIT_W  = (DIST_W > 1) ? $clog2(DIST_W) : 1;

  localparam int OIDX_W = 5;
  localparam int MED_W  = 9;
  localparam int TOT_W  = 6;

  localparam logic [ROW_W-1:0] DESC_MASK = {ROW_W{1'b1}} >> (ROW_W - USED_BITS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [J_W-1:0]    jcnt_t;
  typedef logic [DIST_W-1:0] dist_t;
  typedef logic [PC_W-1:0]   pc_t;
  typedef logic [BIT_W-1:0]  bit_t;
  typedef logic [OIDX_W-1:0] oidx_t;
  typedef logic [MED_W-1:0]  med_t;
  typedef logic [TOT_W-1:0]  tot_t;

  // column tag that travels with a distance through the popcount pipeline
  typedef struct packed {
    logic vld;
    idx_t col;
  } tag_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADI,
    S_CAPI,
    S_DIST,
    S_MCMP,
    S_MCNT,
    S_UPD,
    S_FINISH
  } state_t;

endpackage

@@ hw/rtl/dmmh_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmh_in_if
// descriptor item channel: valid/ready handshake with one descriptor per item
// ----------------------------------------------------------------------------
interface dmmh_in_if;
  logic            valid;
  logic            ready;
  dmmh_pkg::word_t desc_word0;
  dmmh_pkg::word_t desc_word1;
  dmmh_pkg::word_t desc_word2;
  dmmh_pkg::word_t desc_word3;
  logic            usable;
  logic            last;

  modport source (
    output valid, desc_word0, desc_word1, desc_word2, desc_word3, usable, last,
    input  ready
  );
  modport sink (
    input  valid, desc_word0, desc_word1, desc_word2, desc_word3, usable, last,
    output ready
  );
endinterface

@@ hw/rtl/dmmh_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmh_out_if
// selection result channel: valid/ready handshake with one result per item
// ----------------------------------------------------------------------------
interface dmmh_out_if;
  logic            valid;
  logic            ready;
  logic            found;
  dmmh_pkg::oidx_t best_index;
  dmmh_pkg::med_t  best_median;
  dmmh_pkg::tot_t  stored_total;
  logic            overflowed;

  modport source (
    output valid, found, best_index, best_median, stored_total, overflowed,
    input  ready
  );
  modport sink (
    input  valid, found, best_index, best_median, stored_total, overflowed,
    output ready
  );
endinterface

@@ hw/rtl/descriptor_medoid_by_median_hamming.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_medoid_by_median_hamming
// picks the stored binary descriptor whose lower-median hamming distance to
// the set is smallest, then clears the set
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------
//  in_ch    | in  | valid / ready    | desc_word0..3, usable, last
//  out_ch   | out | valid / ready    | found, best_index, best_median,
//           |     |                  | stored_total, overflowed
//
//  an item without last is taken whenever the block is idle
//  an item with last and n stored descriptors keeps in_ch.ready low until the
//  result is loaded: per row one memory read of the base row, n reads
//  through the three-deep hamming pipeline, then 9 bit steps, each a compare
//  state and a count state, for the median search, and one update state
//  the result sits in an output register; a new selection waits in its
//  finish state only while the previous result is still untaken
//  reset is synchronous; the descriptor memory is not cleared
//
`include "descriptor_medoid_by_median_hamming_assert.svh"

module descriptor_medoid_by_median_hamming (
  input  logic        clk,
  input  logic        rst_n,
  dmmh_in_if.sink     in_ch,
  dmmh_out_if.source  out_ch
);

  dmmh_pkg::state_t state_r;
  dmmh_pkg::state_t state_nxt;

  dmmh_pkg::cnt_t   fill_r;
  logic             ovf_r;
  dmmh_pkg::idx_t   best_idx_r;
  dmmh_pkg::dist_t  best_med_r;
  dmmh_pkg::idx_t   i_r;
  dmmh_pkg::jcnt_t  j_r;
  dmmh_pkg::bit_t   bit_r;
  dmmh_pkg::tag_t   iss_tag_r;

  dmmh_pkg::row_t   base_r;
  dmmh_pkg::dist_t  row_r [dmmh_pkg::MAX_DESC];
  logic [dmmh_pkg::MAX_DESC-1:0] le_r;
  dmmh_pkg::dist_t  ans_r;

  logic             out_valid_r;
  logic             out_found_r;
  dmmh_pkg::oidx_t  out_idx_r;
  dmmh_pkg::med_t   out_med_r;
  dmmh_pkg::tot_t   out_total_r;
  logic             out_ovf_r;

  logic             in_acc;
  logic             store_wr;
  dmmh_pkg::cnt_t   fill_after;
  logic             iss;
  logic             rd_en;
  dmmh_pkg::idx_t   rd_addr;
  dmmh_pkg::row_t   rd_data;
  dmmh_pkg::dist_t  col_dist;
  dmmh_pkg::tag_t   dist_tag;
  dmmh_pkg::cnt_t   thresh;
  dmmh_pkg::cnt_t   le_cnt;
  dmmh_pkg::dist_t  cand;
  logic             dist_done;
  logic             upd_last;
  logic             out_load;
  logic             set_found;

  // ---------------------------------------------------------------- datapath

  dmmh_store u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (fill_r[dmmh_pkg::IDX_W-1:0]),
    .wr_data ({in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1, in_ch.desc_word0}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dmmh_hamm u_hamm (
    .clk      (clk),
    .rst_n    (rst_n),
    .row_a    (base_r),
    .row_b    (rd_data),
    .tag_in   (iss_tag_r),
    .dist_out (col_dist),
    .tag_out  (dist_tag)
  );

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign store_wr   = in_acc && in_ch.usable &&
                      (fill_r < dmmh_pkg::cnt_t'(dmmh_pkg::MAX_DESC));
  assign fill_after = fill_r + dmmh_pkg::cnt_t'(store_wr);
  assign set_found  = (fill_r != '0);

  assign iss       = (state_r == dmmh_pkg::S_DIST) && (j_r < dmmh_pkg::jcnt_t'(fill_r));
  assign rd_en     = (state_r == dmmh_pkg::S_LOADI) || iss;
  assign rd_addr   = (state_r == dmmh_pkg::S_LOADI) ? i_r : j_r[dmmh_pkg::IDX_W-1:0];
  // j reaches n + 2 as the last column passes the read, popcount and sum registers into the row buffer
  assign dist_done = (j_r == dmmh_pkg::jcnt_t'(fill_r) + dmmh_pkg::jcnt_t'(2));
  assign upd_last  = (dmmh_pkg::cnt_t'(i_r) == fill_r - dmmh_pkg::cnt_t'(1));

  // lower median is the smallest v with more than (n-1)/2 entries <= v
  assign thresh = ((fill_r - dmmh_pkg::cnt_t'(1)) >> 1) + dmmh_pkg::cnt_t'(1);
  assign cand   = ans_r | ((dmmh_pkg::dist_t'(1) << bit_r) - dmmh_pkg::dist_t'(1));
  assign le_cnt = dmmh_pkg::cnt_t'($countones(le_r));

  assign out_load = (state_r == dmmh_pkg::S_FINISH) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (state_r == dmmh_pkg::S_CAPI) begin
      base_r <= rd_data;
      ans_r  <= '0;
    end
    if (dist_tag.vld) begin
      row_r[dist_tag.col] <= col_dist;
    end
    if (state_r == dmmh_pkg::S_MCMP) begin
      for (int j = 0; j < dmmh_pkg::MAX_DESC; j++) begin
        le_r[j] <= (row_r[j] <= cand) && (dmmh_pkg::cnt_t'(j) < fill_r);
      end
    end
    if ((state_r == dmmh_pkg::S_MCNT) && (le_cnt < thresh)) begin
      ans_r <= ans_r | (dmmh_pkg::dist_t'(1) << bit_r);
    end
    if (out_load) begin
      out_found_r <= set_found;
      out_idx_r   <= set_found ? dmmh_pkg::oidx_t'(best_idx_r) : '0;
      out_med_r   <= set_found ? dmmh_pkg::med_t'(best_med_r) : '0;
      out_total_r <= dmmh_pkg::tot_t'(fill_r);
      out_ovf_r   <= ovf_r;
    end
  end

  // ---------------------------------------------------------------- control

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmmh_pkg::S_IDLE;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      best_idx_r  <= '0;
      best_med_r  <= '1;
      i_r         <= '0;
      j_r         <= '0;
      bit_r       <= '0;
      iss_tag_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      iss_tag_r.vld <= iss;
      iss_tag_r.col <= j_r[dmmh_pkg::IDX_W-1:0];

      if (store_wr) begin
        fill_r <= fill_after;
      end else if (out_load) begin
        fill_r <= '0;
      end

      if (in_acc && in_ch.usable && !store_wr) begin
        ovf_r <= 1'b1;
      end else if (out_load) begin
        ovf_r <= 1'b0;
      end

      unique case (state_r)
        dmmh_pkg::S_CAPI: begin
          j_r   <= '0;
          bit_r <= dmmh_pkg::bit_t'(dmmh_pkg::DIST_W - 1);
        end
        dmmh_pkg::S_DIST: begin
          j_r <= j_r + dmmh_pkg::jcnt_t'(1);
        end
        dmmh_pkg::S_MCNT: begin
          if (bit_r != '0) begin
            bit_r <= bit_r - dmmh_pkg::bit_t'(1);
          end
        end
        dmmh_pkg::S_UPD: begin
          if (ans_r < best_med_r) begin
            best_med_r <= ans_r;
            best_idx_r <= i_r;
          end
          i_r <= i_r + dmmh_pkg::idx_t'(1);
        end
        dmmh_pkg::S_FINISH: begin
          if (out_load) begin
            best_idx_r <= '0;
            best_med_r <= '1;
            i_r        <= '0;
          end
        end
        dmmh_pkg::S_IDLE, dmmh_pkg::S_LOADI, dmmh_pkg::S_MCMP: begin
        end
      endcase

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    unique case (state_r)
      dmmh_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && in_ch.last) begin
          state_nxt = (fill_after == '0) ? dmmh_pkg::S_FINISH : dmmh_pkg::S_LOADI;
        end
      end
      dmmh_pkg::S_LOADI: state_nxt = dmmh_pkg::S_CAPI;
      dmmh_pkg::S_CAPI:  state_nxt = dmmh_pkg::S_DIST;
      dmmh_pkg::S_DIST: begin
        if (dist_done) begin
          state_nxt = dmmh_pkg::S_MCMP;
        end
      end
      dmmh_pkg::S_MCMP:  state_nxt = dmmh_pkg::S_MCNT;
      dmmh_pkg::S_MCNT: begin
        state_nxt = (bit_r == '0) ? dmmh_pkg::S_UPD : dmmh_pkg::S_MCMP;
      end
      dmmh_pkg::S_UPD: begin
        state_nxt = upd_last ? dmmh_pkg::S_FINISH : dmmh_pkg::S_LOADI;
      end
      dmmh_pkg::S_FINISH: begin
        if (out_load) begin
          state_nxt = dmmh_pkg::S_IDLE;
        end
      end
    endcase
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.best_index   = out_idx_r;
  assign out_ch.best_median  = out_med_r;
  assign out_ch.stored_total = out_total_r;
  assign out_ch.overflowed   = out_ovf_r;

  // ---------------------------------------------------------------- checks

  `DMMH_ASSERT_HOLDS(a_fill_in_range, clk, rst_n,
    fill_r <= dmmh_pkg::cnt_t'(dmmh_pkg::MAX_DESC), "fill count beyond store depth")
  `DMMH_ASSERT_IMPLIES(a_median_bound, clk, rst_n, state_r == dmmh_pkg::S_UPD,
    ans_r <= dmmh_pkg::dist_t'(dmmh_pkg::USED_BITS), "row median above descriptor width")
  `DMMH_ASSERT_IMPLIES(a_index_in_set, clk, rst_n, out_valid_r && out_found_r,
    dmmh_pkg::tot_t'(out_idx_r) < out_total_r, "best index outside stored set")
  `DMMH_ASSERT_NEXT(a_last_starts_select, clk, rst_n, in_acc && in_ch.last,
    state_r != dmmh_pkg::S_IDLE, "last item did not start a selection")

endmodule

@@ hw/rtl/dmmh_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmh_store
// descriptor memory, one row per descriptor, one write and one read port
// ----------------------------------------------------------------------------
module dmmh_store (
  input  logic            clk,
  input  logic            wr_en,
  input  dmmh_pkg::idx_t  wr_addr,
  input  dmmh_pkg::row_t  wr_data,
  input  logic            rd_en,
  input  dmmh_pkg::idx_t  rd_addr,
  output dmmh_pkg::row_t  rd_data
);

  dmmh_pkg::row_t mem_r [dmmh_pkg::MAX_DESC];
  dmmh_pkg::row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/dmmh_hamm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmh_hamm
// two-stage hamming distance unit: per-word popcount, then word sum
// ----------------------------------------------------------------------------
module dmmh_hamm (
  input  logic            clk,
  input  logic            rst_n,
  input  dmmh_pkg::row_t  row_a,
  input  dmmh_pkg::row_t  row_b,
  input  dmmh_pkg::tag_t  tag_in,
  output dmmh_pkg::dist_t dist_out,
  output dmmh_pkg::tag_t  tag_out
);

  dmmh_pkg::row_t  diff;
  dmmh_pkg::pc_t   pc_r [dmmh_pkg::WORDS];
  dmmh_pkg::tag_t  tag1_r;
  dmmh_pkg::tag_t  tag2_r;
  dmmh_pkg::dist_t dist_r;
  dmmh_pkg::dist_t sum;

  assign diff = (row_a ^ row_b) & dmmh_pkg::DESC_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < dmmh_pkg::WORDS; w++) begin
      pc_r[w] <= dmmh_pkg::pc_t'($countones(diff[w*dmmh_pkg::WORD_W +: dmmh_pkg::WORD_W]));
    end
    dist_r <= sum;
  end

  always_comb begin
    sum = '0;
    for (int w = 0; w < dmmh_pkg::WORDS; w++) begin
      sum = sum + dmmh_pkg::dist_t'(pc_r[w]);
    end
  end

  assign dist_out = dist_r;
  assign tag_out  = tag2_r;

endmodule
